### hdl/syscall_latency_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Syscall latency accumulator assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef SYSCALL_LATENCY_ACCUMULATOR_DEFINES_SVH
`define SYSCALL_LATENCY_ACCUMULATOR_DEFINES_SVH

// next-cycle implication, quiet while reset is high
`define SLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slc: assertion failed");

// next-cycle implication, checked through reset as well
`define SLC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("slc: assertion failed");

`endif

### hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Types, codes and defaults shared by the syscall latency accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

   localparam int ID_SLOTS_DEF   = 512;
   localparam int PEND_SLOTS_DEF = 64;

   // register file: two 32-bit registers, byte addressed
   localparam int CSR_AW = 3;
   localparam logic REG_LATENCY_MODE   = 1'b0;
   localparam logic REG_FILTER_PROCESS = 1'b1;

   localparam logic [31:0] NO_FILTER = 32'hFFFF_FFFF;

   localparam logic CMD_ENTRY = 1'b0;
   localparam logic CMD_EXIT  = 1'b1;

   localparam logic [2:0] ST_COUNTED    = 3'd0;
   localparam logic [2:0] ST_FILTERED   = 3'd1;
   localparam logic [2:0] ST_RECORDED   = 3'd2;
   localparam logic [2:0] ST_NO_PENDING = 3'd3;
   localparam logic [2:0] ST_FULL       = 3'd4;
   localparam logic [2:0] ST_RANGE      = 3'd5;

   typedef struct packed {
      logic        latency_mode;
      logic [31:0] filter_process;
   } cfg_type;

   typedef struct packed {
      logic [63:0] call_count;
      logic [63:0] total_time_ns;
   } stat_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] key;
      logic [9:0]  call_id;
      logic [63:0] start_ns;
   } pend_type;

endpackage

`default_nettype wire

### hdl/slc_csr.sv
// ----------------------------------------------------------------------------
// slc_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_csr (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [slc_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire  [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output slc_pkg::cfg_type            cfg
);

   slc_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_beat;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel && csr_penable && csr_pwrite;

   // word decode: low two address bits are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         case (csr_paddr[2])
            slc_pkg::REG_LATENCY_MODE:   cfg_in.latency_mode   = csr_pwdata[0];
            slc_pkg::REG_FILTER_PROCESS: cfg_in.filter_process = csr_pwdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         slc_pkg::REG_LATENCY_MODE:   csr_prdata = {31'b0, cfg_ff.latency_mode};
         slc_pkg::REG_FILTER_PROCESS: csr_prdata = cfg_ff.filter_process;
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.latency_mode   <= 1'b0;
         cfg_ff.filter_process <= slc_pkg::NO_FILTER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/slc_stat_mem.sv
// ----------------------------------------------------------------------------
// slc_stat_mem
// Per-call-id statistics RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_stat_mem #(
   parameter int DEPTH = slc_pkg::ID_SLOTS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire  [AW-1:0]           wr_addr,
   input  slc_pkg::stat_type       wr_data,
   input  wire  [AW-1:0]           rd_addr,
   output slc_pkg::stat_type       rd_data
);

   slc_pkg::stat_type mem_ff [DEPTH];
   slc_pkg::stat_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/slc_pend_mem.sv
// ----------------------------------------------------------------------------
// slc_pend_mem
// Pending-call RAM: valid, thread key, call id and start time per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module slc_pend_mem #(
   parameter int DEPTH = slc_pkg::PEND_SLOTS_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire  [AW-1:0]           wr_addr,
   input  slc_pkg::pend_type       wr_data,
   input  wire  [AW-1:0]           rd_addr,
   output slc_pkg::pend_type       rd_data
);

   slc_pkg::pend_type mem_ff [DEPTH];
   slc_pkg::pend_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/syscall_latency_accumulator.sv
// ----------------------------------------------------------------------------
// syscall_latency_accumulator
// Entry/exit event profiler: per-call-id counts and accumulated latency.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its RAMs over max(ID_SLOTS,
// PENDING_SLOTS) slot addresses with req_stall high (register writes are taken).
// Then one event is processed at a time and every event gives exactly one
// result beat. Filtered events and out-of-range entries go straight to the
// result; a count-mode entry does a read-modify-write of the statistics RAM.
// A latency entry or an exit first runs a linear search of the whole pending
// RAM, one slot per cycle through its single read port; an entry dropped on a
// full table or an exit with no pending record then ends, while a recorded
// entry reads and a matched exit updates the statistics entry. A finished
// result sits in the output register while the next event is accepted; it
// only waits there if rsp_stall holds.
// ----------------------------------------------------------------------------
`default_nettype none

module syscall_latency_accumulator #(
   parameter int ID_SLOTS      = slc_pkg::ID_SLOTS_DEF,
   parameter int PENDING_SLOTS = slc_pkg::PEND_SLOTS_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   // event beats
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire                         req_cmd,
   input  wire  [31:0]                 req_process_id,
   input  wire  [31:0]                 req_thread_id,
   input  wire  [9:0]                  req_call_id,
   input  wire  [63:0]                 req_now_ns,
   // result beats
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [9:0]                  rsp_stat_id,
   output logic [63:0]                 rsp_call_count,
   output logic [63:0]                 rsp_total_time_ns,
   // register port
   input  wire                         csr_psel,
   input  wire                         csr_penable,
   input  wire                         csr_pwrite,
   input  wire  [slc_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire  [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int ID_AW = $clog2(ID_SLOTS);
   localparam int P_AW  = $clog2(PENDING_SLOTS);
   localparam int CLR_N = (ID_SLOTS > PENDING_SLOTS) ? ID_SLOTS : PENDING_SLOTS;
   localparam int CLR_W = $clog2(CLR_N);

   localparam logic [10:0]      ID_LIM     = 11'(ID_SLOTS);
   localparam logic [P_AW-1:0]  P_LAST     = P_AW'(PENDING_SLOTS - 1);
   localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_N - 1);
   localparam logic [CLR_W:0]   CLR_ID_LIM = (CLR_W + 1)'(ID_SLOTS);
   localparam logic [CLR_W:0]   CLR_P_LIM  = (CLR_W + 1)'(PENDING_SLOTS);

   // sequencer states
   localparam logic [2:0] S_CLEAR   = 3'd0;  // post-reset RAM sweep
   localparam logic [2:0] S_IDLE    = 3'd1;  // ready for an event
   localparam logic [2:0] S_SCAN    = 3'd2;  // issue pending RAM reads
   localparam logic [2:0] S_SCANW   = 3'd3;  // last read data returns
   localparam logic [2:0] S_RESOLVE = 3'd4;  // update pending slot
   localparam logic [2:0] S_SREAD   = 3'd5;  // stats RAM read in flight
   localparam logic [2:0] S_SMOD    = 3'd6;  // stats modify + write back
   localparam logic [2:0] S_DONE    = 3'd7;  // hand result to output reg

   slc_pkg::cfg_type  cfg;
   slc_pkg::stat_type stat_rd, stat_wr_data;
   slc_pkg::pend_type pend_rd, pend_wr_data;
   logic              stat_wr_en, pend_wr_en;
   logic [ID_AW-1:0]  stat_wr_addr;
   logic [P_AW-1:0]   pend_wr_addr;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // event context
   logic              cmd_ff, cmd_in;
   logic [63:0]       key_ff, key_in;
   logic [9:0]        call_ff, call_in;
   logic [63:0]       now_ff, now_in;

   // search
   logic [P_AW-1:0]   scan_ff, scan_in;
   logic [P_AW-1:0]   rd_idx_ff, rd_idx_in;
   logic              hit_found_ff, hit_found_in;
   logic [P_AW-1:0]   hit_idx_ff, hit_idx_in;
   logic [9:0]        hit_call_ff, hit_call_in;
   logic [63:0]       hit_start_ff, hit_start_in;
   logic              free_found_ff, free_found_in;
   logic [P_AW-1:0]   free_idx_ff, free_idx_in;

   // stats update
   logic [ID_AW-1:0]  stat_addr_ff, stat_addr_in;
   logic              inc_ff, inc_in;
   logic              add_ff, add_in;
   logic [63:0]       delta_ff, delta_in;
   logic [63:0]       cnt_new, tot_new;

   // pending result
   logic [2:0]        res_status_ff, res_status_in;
   logic [9:0]        res_id_ff, res_id_in;
   logic [63:0]       res_cnt_ff, res_cnt_in;
   logic [63:0]       res_tot_ff, res_tot_in;

   // output register
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [9:0]        rsp_id_ff, rsp_id_in;
   logic [63:0]       rsp_cnt_ff, rsp_cnt_in;
   logic [63:0]       rsp_tot_ff, rsp_tot_in;

   logic              req_beat;
   logic              req_filtered;
   logic              req_in_range;
   logic              hit_in_range;
   logic              out_free;
   logic              clr_in_id, clr_in_p;

   slc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   slc_stat_mem #(.DEPTH(ID_SLOTS)) u_stat_mem (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (stat_wr_data),
      .rd_addr (stat_addr_ff),
      .rd_data (stat_rd)
   );

   slc_pend_mem #(.DEPTH(PENDING_SLOTS)) u_pend_mem (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_addr (scan_ff),
      .rd_data (pend_rd)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Filter: -1 passes everything; any other negative value matches nothing.
   assign req_filtered = (cfg.filter_process != slc_pkg::NO_FILTER) &&
                         (cfg.filter_process[31] ||
                          (cfg.filter_process != req_process_id));

   assign req_in_range = ({1'b0, req_call_id} < ID_LIM);
   assign hit_in_range = ({1'b0, hit_call_ff} < ID_LIM);

   assign clr_in_id = ({1'b0, clr_ff} < CLR_ID_LIM);
   assign clr_in_p  = ({1'b0, clr_ff} < CLR_P_LIM);

   // Read-modify-write of the stats entry; data arrives in S_SMOD.
   assign cnt_new = stat_rd.call_count + 64'(inc_ff);
   assign tot_new = stat_rd.total_time_ns + (add_ff ? delta_ff : 64'd0);

   // Stats RAM write: zero sweep after reset, else the update.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         stat_wr_en   = clr_in_id;
         stat_wr_addr = clr_ff[ID_AW-1:0];
         stat_wr_data = '0;
      end else begin
         stat_wr_en   = (state_ff == S_SMOD) && inc_ff;
         stat_wr_addr = stat_addr_ff;
         stat_wr_data = '{call_count: cnt_new, total_time_ns: tot_new};
      end
   end

   // Pending RAM write: invalidate sweep after reset, else the slot update.
   // An exit only clears valid; the other fields stay don't-care.
   always_comb begin
      if (state_ff == S_CLEAR) begin
         pend_wr_en   = clr_in_p;
         pend_wr_addr = clr_ff[P_AW-1:0];
         pend_wr_data = '0;
      end else begin
         pend_wr_en   = (state_ff == S_RESOLVE) &&
                        (hit_found_ff || ((cmd_ff == slc_pkg::CMD_ENTRY) && free_found_ff));
         pend_wr_addr = hit_found_ff ? hit_idx_ff : free_idx_ff;
         pend_wr_data = '{valid:    (cmd_ff == slc_pkg::CMD_ENTRY),
                          key:      key_ff,
                          call_id:  call_ff,
                          start_ns: now_ff};
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rd_vld_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      cmd_in        = cmd_ff;
      key_in        = key_ff;
      call_in       = call_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      rd_idx_in     = rd_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_call_in   = hit_call_ff;
      hit_start_in  = hit_start_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      stat_addr_in  = stat_addr_ff;
      inc_in        = inc_ff;
      add_in        = add_ff;
      delta_in      = delta_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_cnt_in    = res_cnt_ff;
      res_tot_in    = res_tot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_tot_in    = rsp_tot_ff;

      // Search compare, one slot per cycle behind the RAM read.
      // First valid key match wins; first invalid slot is the free one.
      if (rd_vld_ff) begin
         if (pend_rd.valid) begin
            if (!hit_found_ff && (pend_rd.key == key_ff)) begin
               hit_found_in = 1'b1;
               hit_idx_in   = rd_idx_ff;
               hit_call_in  = pend_rd.call_id;
               hit_start_in = pend_rd.start_ns;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_beat) begin
               cmd_in        = req_cmd;
               key_in        = {req_process_id, req_thread_id};
               call_in       = req_call_id;
               now_in        = req_now_ns;
               stat_addr_in  = req_call_id[ID_AW-1:0];
               res_id_in     = req_call_id;
               res_cnt_in    = '0;
               res_tot_in    = '0;
               inc_in        = 1'b0;
               add_in        = 1'b0;
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               if (req_filtered) begin
                  res_status_in = slc_pkg::ST_FILTERED;
                  res_id_in     = '0;
                  state_in      = S_DONE;
               end else if ((req_cmd == slc_pkg::CMD_ENTRY) && !req_in_range) begin
                  res_status_in = slc_pkg::ST_RANGE;
                  state_in      = S_DONE;
               end else if ((req_cmd == slc_pkg::CMD_ENTRY) && !cfg.latency_mode) begin
                  // count mode: bump the counter only
                  res_status_in = slc_pkg::ST_COUNTED;
                  inc_in        = 1'b1;
                  state_in      = S_SREAD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            rd_vld_in = 1'b1;
            rd_idx_in = scan_ff;
            if (scan_ff == P_LAST) begin
               state_in = S_SCANW;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         S_SCANW: begin
            state_in = S_RESOLVE;
         end

         S_RESOLVE: begin
            if (cmd_ff == slc_pkg::CMD_ENTRY) begin
               if (hit_found_ff || free_found_ff) begin
                  // record (or overwrite) the thread's start; report stats
                  res_status_in = slc_pkg::ST_RECORDED;
                  state_in      = S_SREAD;
               end else begin
                  res_status_in = slc_pkg::ST_FULL;
                  state_in      = S_DONE;
               end
            end else if (!hit_found_ff) begin
               res_status_in = slc_pkg::ST_NO_PENDING;
               res_id_in     = '0;
               state_in      = S_DONE;
            end else begin
               res_id_in    = hit_call_ff;
               stat_addr_in = hit_call_ff[ID_AW-1:0];
               if (!hit_in_range) begin
                  res_status_in = slc_pkg::ST_RANGE;
                  state_in      = S_DONE;
               end else begin
                  res_status_in = slc_pkg::ST_COUNTED;
                  inc_in        = 1'b1;
                  add_in        = 1'b1;
                  delta_in      = now_ff - hit_start_ff;  // wraps mod 2^64
                  state_in      = S_SREAD;
               end
            end
         end

         S_SREAD: begin
            state_in = S_SMOD;
         end

         S_SMOD: begin
            res_cnt_in = cnt_new;
            res_tot_in = tot_new;
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_cnt_in    = res_cnt_ff;
               rsp_tot_in    = res_tot_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      call_ff       <= call_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      hit_call_ff   <= hit_call_in;
      hit_start_ff  <= hit_start_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      stat_addr_ff  <= stat_addr_in;
      inc_ff        <= inc_in;
      add_ff        <= add_in;
      delta_ff      <= delta_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_cnt_ff    <= res_cnt_in;
      res_tot_ff    <= res_tot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_tot_ff    <= rsp_tot_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_stat_id       = rsp_id_ff;
   assign rsp_call_count    = rsp_cnt_ff;
   assign rsp_total_time_ns = rsp_tot_ff;

endmodule

`default_nettype wire

### hdl/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks for the syscall latency accumulator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "syscall_latency_accumulator_defines.svh"

module slc_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [2:0]  rsp_status,
   input wire [9:0]  rsp_stat_id,
   input wire [63:0] rsp_call_count,
   input wire [63:0] rsp_total_time_ns
);

   // whole result payload, for the hold check
   logic [140:0] rsp_beat;

   assign rsp_beat = {rsp_status, rsp_stat_id, rsp_call_count, rsp_total_time_ns};

   // a stalled result beat stays put
   `SLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // one event at a time: an accepted beat closes the input in the next cycle
   `SLC_ASSERT_NEXT(a_req_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall)

   // reset starts the RAM sweep with nothing on the output
   `SLC_ASSERT_NEXT_ALWAYS(a_reset_sweep, clock, reset, req_stall && !rsp_valid)

endmodule

bind syscall_latency_accumulator slc_checker u_slc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_stat_id       (rsp_stat_id),
   .rsp_call_count    (rsp_call_count),
   .rsp_total_time_ns (rsp_total_time_ns)
);

`default_nettype wire
